// ===== hdl/p2sca_pkg.sv =====
// Shared types and constants for the power-of-two size-class block allocator.
`default_nettype none

package p2sca_pkg;

  localparam int CFG_W      = 14;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int SIZE_W     = 16;
  localparam int IN_ADDR_W  = 24;
  localparam int OUT_ADDR_W = 24;
  localparam int OUT_CLS_W  = 3;
  localparam int STATUS_W   = 3;

  localparam logic [CFG_W-1:0] CNT_SAT = '1;

  localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
    14'd8192, 14'd8192, 14'd4096, 14'd4096, 14'd2048, 14'd0, 14'd0, 14'd1024
  };

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIZE   = 3'd1,
    ST_NO_BLOCKS  = 3'd2,
    ST_FOREIGN    = 3'd3,
    ST_MISALIGNED = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic busy;
    logic step;
  } sweep_t;

  typedef struct packed {
    logic hit;
    logic aligned;
  } free_chk_t;

endpackage

`default_nettype wire

// ===== hdl/pow2_size_class_block_allocator.sv =====
// Top level of the power-of-two size-class block allocator.
//
// A request is taken in the accept cycle and finished in S_EXEC: in the accept
// cycle the size class is chosen (or the free address matched to its region)
// and, for an allocation from a freed list, the head link of the class's freed
// list is read from the link memory; in S_EXEC the class state and, for a free,
// the link memory are written back and the result word is loaded into the output
// register; the registered read of the link memory ahead of its write-back is
// why the work is split so. A result word that waits at the output holds S_EXEC.
// After reset and every count register write the region bounds are rebuilt,
// one class a cycle unless a register is written; no request is taken meanwhile.
`default_nettype none

module pow2_size_class_block_allocator #(
  parameter int NUM_CLASSES    = 8,
  parameter int MIN_BLOCK_LOG2 = 3,
  parameter int MAX_BLOCKS     = 8192,
  parameter int ADDR_BITS      = 24
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [p2sca_pkg::REG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [p2sca_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               kind_i,
  input  wire logic [p2sca_pkg::SIZE_W-1:0]       request_size_i,
  input  wire logic [p2sca_pkg::IN_ADDR_W-1:0]    free_address_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    granted_o,
  output logic      [p2sca_pkg::OUT_ADDR_W-1:0]   block_address_o,
  output logic      [p2sca_pkg::OUT_CLS_W-1:0]    served_class_o,
  output logic      [p2sca_pkg::STATUS_W-1:0]     status_o
);

  import p2sca_pkg::*;

  localparam int CLS_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int IDX_W    = $clog2(MAX_BLOCKS);
  localparam int LOG2_MAX = MIN_BLOCK_LOG2 + NUM_CLASSES - 1;
  localparam int SUM_W    = CFG_W + LOG2_MAX + CLS_W + 1;
  localparam int BASE_W   = (SUM_W > IN_ADDR_W) ? SUM_W : IN_ADDR_W;
  localparam int LINK_AW  = CLS_W + IDX_W;
  localparam int P_W      = $clog2(SIZE_W + 1);

  state_e state_q, state_d;

  logic [CFG_W-1:0] untouched_q [NUM_CLASSES];
  logic [CFG_W-1:0] fcnt_q      [NUM_CLASSES];
  logic [IDX_W-1:0] top_q       [NUM_CLASSES];

  sweep_t           sweep;
  logic [CLS_W-1:0] step_cls;
  logic [CFG_W-1:0] step_cnt;
  free_chk_t        chk;
  logic [CLS_W-1:0] free_cls;
  logic [IDX_W-1:0] free_idx;
  logic [BASE_W-1:0] base_sel;

  // accept-cycle decode
  logic [SIZE_W-1:0] sm1;
  logic [P_W-1:0]    p;
  logic              bad_size;
  int                start;
  logic              found;
  logic [CLS_W-1:0]  a_cls;
  logic [CLS_W-1:0]  sel_cls;
  logic [IDX_W-1:0]  top_sel;
  logic [CFG_W-1:0]  fcnt_sel;
  logic [CFG_W-1:0]  unt_sel;
  logic              pop;
  logic              grant_d;
  status_e           status_d;
  logic [CLS_W-1:0]  cls_d;
  logic [IDX_W-1:0]  idx_d;
  logic              accept;
  logic              commit;

  // item registers
  logic              op_free_q;
  logic              grant_q;
  logic              pop_q;
  status_e           status_q;
  logic [CLS_W-1:0]  icls_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  link_wd_q;
  logic [CFG_W-1:0]  fcnt_item_q;

  logic [IDX_W-1:0]  link_rdata;
  logic [BASE_W-1:0] addr_full;
  logic [OUT_ADDR_W-1:0] addr_out;

  // output register
  logic                  out_valid_q;
  logic                  granted_q;
  logic [OUT_ADDR_W-1:0] addr_q;
  logic [OUT_CLS_W-1:0]  ocls_q;
  status_e               ostatus_q;

  p2sca_region_map #(
    .NUM_CLASSES   (NUM_CLASSES),
    .MIN_BLOCK_LOG2(MIN_BLOCK_LOG2),
    .MAX_BLOCKS    (MAX_BLOCKS),
    .CLS_W         (CLS_W),
    .IDX_W         (IDX_W),
    .BASE_W        (BASE_W)
  ) u_region_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .sweep_o    (sweep),
    .step_cls_o (step_cls),
    .step_cnt_o (step_cnt),
    .free_addr_i(free_address_i),
    .chk_o      (chk),
    .free_cls_o (free_cls),
    .free_idx_o (free_idx),
    .base_sel_i (icls_q),
    .base_o     (base_sel)
  );

  p2sca_link_mem #(
    .AW(LINK_AW),
    .DW(IDX_W)
  ) u_link_mem (
    .clk_i  (clk_i),
    .we_i   (commit && grant_q && op_free_q),
    .waddr_i({icls_q, idx_q}),
    .wdata_i(link_wd_q),
    .re_i   (accept && (kind_i == KIND_ALLOC) && grant_d && pop),
    .raddr_i({sel_cls, top_sel}),
    .rdata_o(link_rdata)
  );

  // size class search and request decode
  always_comb begin
    sm1 = request_size_i - SIZE_W'(1);
    p   = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (sm1[i]) begin
        p = P_W'(i + 1);
      end
    end
    bad_size = (request_size_i == '0) || (int'(p) > LOG2_MAX);
    start    = (int'(p) <= MIN_BLOCK_LOG2) ? 0 : int'(p) - MIN_BLOCK_LOG2;

    found = 1'b0;
    a_cls = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (!found && c >= start && (fcnt_q[c] != '0 || untouched_q[c] != '0)) begin
        found = 1'b1;
        a_cls = CLS_W'(c);
      end
    end

    sel_cls  = (kind_i == KIND_FREE) ? free_cls : a_cls;
    top_sel  = top_q[sel_cls];
    fcnt_sel = fcnt_q[sel_cls];
    unt_sel  = untouched_q[sel_cls];
    pop      = fcnt_sel != '0;

    grant_d = 1'b0;
    cls_d   = '0;
    idx_d   = free_idx;
    if (kind_i == KIND_ALLOC) begin
      idx_d = pop ? top_sel : IDX_W'(unt_sel - CFG_W'(1));
      if (bad_size) begin
        status_d = ST_BAD_SIZE;
      end else if (!found) begin
        status_d = ST_NO_BLOCKS;
      end else begin
        status_d = ST_OK;
        grant_d  = 1'b1;
        cls_d    = sel_cls;
      end
    end else begin
      if (!chk.hit) begin
        status_d = ST_FOREIGN;
      end else if (!chk.aligned) begin
        status_d = ST_MISALIGNED;
        cls_d    = sel_cls;
      end else begin
        status_d = ST_OK;
        grant_d  = 1'b1;
        cls_d    = sel_cls;
      end
    end
  end

  assign commit = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = !sweep.busy;
        if (in_valid_i && !sweep.busy) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_free_q   <= kind_i == KIND_FREE;
      grant_q     <= grant_d;
      pop_q       <= pop;
      status_q    <= status_d;
      icls_q      <= cls_d;
      idx_q       <= idx_d;
      link_wd_q   <= top_sel;
      fcnt_item_q <= fcnt_sel;
    end
  end

  // per-class counters: rebuilt by the sweep, updated at writeback
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        untouched_q[c] <= '0;
        fcnt_q[c]      <= '0;
      end
    end else if (sweep.step) begin
      untouched_q[step_cls] <= step_cnt;
      fcnt_q[step_cls]      <= '0;
    end else if (commit && grant_q) begin
      if (op_free_q) begin
        if (fcnt_item_q != CNT_SAT) begin
          fcnt_q[icls_q] <= fcnt_item_q + CFG_W'(1);
        end
      end else if (pop_q) begin
        fcnt_q[icls_q] <= fcnt_item_q - CFG_W'(1);
      end else begin
        untouched_q[icls_q] <= CFG_W'(idx_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && grant_q) begin
      if (op_free_q) begin
        top_q[icls_q] <= idx_q;
      end else if (pop_q) begin
        top_q[icls_q] <= link_rdata;
      end
    end
  end

  always_comb begin
    addr_full = base_sel + (BASE_W'(idx_q) << (MIN_BLOCK_LOG2 + int'(icls_q)));
    for (int i = 0; i < OUT_ADDR_W; i++) begin
      addr_out[i] = (i < ADDR_BITS) ? addr_full[i] : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      granted_q <= grant_q;
      addr_q    <= (grant_q && !op_free_q) ? addr_out : '0;
      ocls_q    <= OUT_CLS_W'(icls_q);
      ostatus_q <= status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = granted_q;
  assign block_address_o = addr_q;
  assign served_class_o  = ocls_q;
  assign status_o        = ostatus_q;

endmodule

`default_nettype wire

// ===== hdl/p2sca_link_mem.sv =====
// Synchronous link memory: one write port, one read port, registered read data.
`default_nettype none

module p2sca_link_mem #(
  parameter int AW = 16,
  parameter int DW = 13
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/p2sca_region_map.sv =====
// Count registers, region bound sweep and free-address region lookup.
`default_nettype none

module p2sca_region_map #(
  parameter int NUM_CLASSES    = 8,
  parameter int MIN_BLOCK_LOG2 = 3,
  parameter int MAX_BLOCKS     = 8192,
  parameter int CLS_W          = 3,
  parameter int IDX_W          = 13,
  parameter int BASE_W         = 29
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [p2sca_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [p2sca_pkg::CFG_W-1:0]       cfg_data_i,
  output p2sca_pkg::sweep_t                      sweep_o,
  output logic      [CLS_W-1:0]                  step_cls_o,
  output logic      [p2sca_pkg::CFG_W-1:0]       step_cnt_o,
  input  wire logic [p2sca_pkg::IN_ADDR_W-1:0]   free_addr_i,
  output p2sca_pkg::free_chk_t                   chk_o,
  output logic      [CLS_W-1:0]                  free_cls_o,
  output logic      [IDX_W-1:0]                  free_idx_o,
  input  wire logic [CLS_W-1:0]                  base_sel_i,
  output logic      [BASE_W-1:0]                 base_o
);

  import p2sca_pkg::*;

  logic [CFG_W-1:0]     regs_q [NUM_REGS];
  logic                 busy_q;
  logic [CLS_W-1:0]     k_q;
  logic [BASE_W-1:0]    acc_q;
  logic [BASE_W-1:0]    hi_q [NUM_CLASSES];
  logic [BASE_W-1:0]    lo_w [NUM_CLASSES];
  logic [REG_IDX_W-1:0] k_reg;
  logic [CFG_W-1:0]     k_raw;
  logic [CFG_W-1:0]     k_cnt;
  logic [BASE_W-1:0]    term;
  logic [BASE_W-1:0]    a_ext;
  logic                 step;

  // block count of the class under sweep, clamped
  always_comb begin
    k_reg = REG_IDX_W'(k_q);
    k_raw = regs_q[k_reg];
    if (int'(k_q) >= NUM_REGS) begin
      k_cnt = '0;
    end else if (int'(k_raw) > MAX_BLOCKS) begin
      k_cnt = CFG_W'(MAX_BLOCKS);
    end else begin
      k_cnt = k_raw;
    end
    term = BASE_W'(k_cnt) << (MIN_BLOCK_LOG2 + int'(k_q));
  end

  assign step       = busy_q && !cfg_we_i;
  assign sweep_o    = '{busy: busy_q, step: step};
  assign step_cls_o = k_q;
  assign step_cnt_o = k_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= REG_RESET[i];
      end
    end else if (cfg_we_i && (int'(cfg_index_i) < NUM_REGS)) begin
      regs_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      k_q    <= '0;
      acc_q  <= '0;
    end else if (cfg_we_i) begin
      busy_q <= 1'b1;
      k_q    <= '0;
      acc_q  <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + term;
      k_q   <= k_q + CLS_W'(1);
      if (int'(k_q) == NUM_CLASSES - 1) begin
        busy_q <= 1'b0;
      end
    end
  end

  // upper bound of each region, one class per cycle while no register is written
  always_ff @(posedge clk_i) begin
    if (step) begin
      hi_q[k_q] <= acc_q + term;
    end
  end

  always_comb begin
    lo_w[0] = '0;
    for (int c = 1; c < NUM_CLASSES; c++) begin
      lo_w[c] = hi_q[c-1];
    end
  end

  assign base_o = lo_w[base_sel_i];

  // regions are disjoint, so at most one matches
  always_comb begin
    logic [BASE_W-1:0] off;
    a_ext      = BASE_W'(free_addr_i);
    chk_o      = '{hit: 1'b0, aligned: 1'b0};
    free_cls_o = '0;
    free_idx_o = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      off = a_ext - lo_w[c];
      if (a_ext >= lo_w[c] && a_ext < hi_q[c]) begin
        chk_o.hit     = 1'b1;
        chk_o.aligned = (off & ((BASE_W'(1) << (MIN_BLOCK_LOG2 + c)) - BASE_W'(1))) == '0;
        free_cls_o    = CLS_W'(c);
        free_idx_o    = IDX_W'(off >> (MIN_BLOCK_LOG2 + c));
      end
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_pow2_size_class_block_allocator.sv =====
// Testbench for the power-of-two size-class block allocator: random and directed requests.
`timescale 1ns / 100ps

module tb_pow2_size_class_block_allocator;
  import p2sca_pkg::*;

  localparam int NUM_CLASSES    = 8;
  localparam int MIN_BLOCK_LOG2 = 3;
  localparam int MAX_BLOCKS     = 8192;
  localparam int NUM_PHASES     = 13;

  typedef struct {
    bit        granted;
    bit [23:0] addr;
    bit [2:0]  cls;
    status_e   status;
  } grant_word_t;

  class block_pool_tracker;
    bit [CFG_W-1:0] count_reg [NUM_REGS];
    bit [13:0]      untouched [NUM_CLASSES];
    bit [13:0]      freed_cnt [NUM_CLASSES];
    bit [12:0]      freed_head [NUM_CLASSES];
    bit [12:0]      link_mem [NUM_CLASSES][MAX_BLOCKS];
    grant_word_t    due_words [$];
    bit [23:0]      live_blocks [$];
    bit [23:0]      last_alloc;
    int             errors;
    int             checked;

    function new();
      foreach (count_reg[i]) count_reg[i] = REG_RESET[i];
      format_pool();
    endfunction

    function int unsigned blocks_of(int c);
      if (c >= NUM_REGS) return 0;
      return (count_reg[c] > MAX_BLOCKS) ? MAX_BLOCKS : 32'(count_reg[c]);
    endfunction

    function longint unsigned region_base(int c);
      longint unsigned base;
      base = 0;
      for (int k = 0; k < c; k++) base += longint'(blocks_of(k)) << (MIN_BLOCK_LOG2 + k);
      return base;
    endfunction

    function void format_pool();
      for (int c = 0; c < NUM_CLASSES; c++) begin
        untouched[c]  = 14'(blocks_of(c));
        freed_cnt[c]  = 0;
        freed_head[c] = 0;
      end
      live_blocks.delete();
    endfunction

    function void write_reg(int idx, bit [CFG_W-1:0] value);
      count_reg[idx] = value;
      format_pool();
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function void note_request(bit kind, bit [15:0] size, bit [23:0] faddr);
      grant_word_t     w;
      int unsigned     p, start, idx;
      longint unsigned base, len, off;
      w.granted = 0;
      w.addr    = 0;
      w.cls     = 0;
      if (kind == KIND_ALLOC) begin
        p = 0;
        while (p < 16 && (32'd1 << p) < size) p++;
        if (size == 0 || p > MIN_BLOCK_LOG2 + NUM_CLASSES - 1) begin
          w.status = ST_BAD_SIZE;
        end else begin
          start    = (p <= MIN_BLOCK_LOG2) ? 0 : p - MIN_BLOCK_LOG2;
          w.status = ST_NO_BLOCKS;
          for (int c = start; c < NUM_CLASSES; c++) begin
            if (freed_cnt[c] > 0) begin
              idx           = 32'(freed_head[c]);
              freed_head[c] = link_mem[c][idx];
              freed_cnt[c]--;
            end else if (untouched[c] > 0) begin
              untouched[c]--;
              idx = 32'(untouched[c]);
            end else begin
              continue;
            end
            w.granted = 1;
            w.status  = ST_OK;
            w.cls     = 3'(c);
            w.addr    = 24'(region_base(c) + (longint'(idx) << (MIN_BLOCK_LOG2 + c)));
            last_alloc = w.addr;
            live_blocks.push_back(w.addr);
            break;
          end
        end
      end else begin
        base     = 0;
        w.status = ST_FOREIGN;
        for (int c = 0; c < NUM_CLASSES; c++) begin
          len = longint'(blocks_of(c)) << (MIN_BLOCK_LOG2 + c);
          if (faddr >= base && faddr < base + len) begin
            off   = faddr - base;
            w.cls = 3'(c);
            if ((off & ((longint'(1) << (MIN_BLOCK_LOG2 + c)) - 1)) != 0) begin
              w.status = ST_MISALIGNED;
            end else begin
              idx           = 32'(off >> (MIN_BLOCK_LOG2 + c));
              link_mem[c][idx] = freed_head[c];
              freed_head[c] = 13'(idx);
              if (freed_cnt[c] != CNT_SAT) freed_cnt[c]++;
              w.granted = 1;
              w.status  = ST_OK;
            end
            break;
          end
          base += len;
        end
      end
      due_words.push_back(w);
    endfunction

    function void check_result(logic g, logic [23:0] a, logic [2:0] c, logic [2:0] st);
      grant_word_t w;
      checked++;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected result word: granted %0d addr %h class %0d status %0d",
                 $time, g, a, c, st);
        errors++;
        return;
      end
      w = due_words.pop_front();
      if (g !== w.granted) begin
        $display("%0t: granted expected %0d actual %0d", $time, w.granted, g);
        errors++;
      end
      if (a !== w.addr) begin
        $display("%0t: block_address expected %h actual %h", $time, w.addr, a);
        errors++;
      end
      if (c !== w.cls) begin
        $display("%0t: served_class expected %0d actual %0d", $time, w.cls, c);
        errors++;
      end
      if (st !== w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, w.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_W-1:0]      cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  kind_i         = 1'b0;
  logic [SIZE_W-1:0]     request_size_i = '0;
  logic [IN_ADDR_W-1:0]  free_address_i = '0;
  logic                  out_ready_i    = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  granted_o;
  logic [OUT_ADDR_W-1:0] block_address_o;
  logic [OUT_CLS_W-1:0]  served_class_o;
  logic [STATUS_W-1:0]   status_o;

  block_pool_tracker pool = new();

  pow2_size_class_block_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .request_size_i (request_size_i),
    .free_address_i (free_address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .granted_o      (granted_o),
    .block_address_o(block_address_o),
    .served_class_o (served_class_o),
    .status_o       (status_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_word(bit kind, bit [15:0] size, bit [23:0] faddr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    request_size_i <= size;
    free_address_i <= faddr;
    do @(posedge clk_i); while (!in_ready_o);
    pool.note_request(kind, size, faddr);
  endtask

  task automatic request_block(bit [15:0] size);
    send_word(KIND_ALLOC, size, 24'($urandom));
  endtask

  task automatic return_block(bit [23:0] faddr);
    send_word(KIND_FREE, 16'($urandom), faddr);
  endtask

  task automatic send_random();
    int        r, k, pick;
    bit [15:0] size;
    bit [23:0] faddr;
    r = $urandom_range(0, 99);
    if (r < 45 || (pool.live_blocks.size() == 0 && r < 85)) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 3))
          0:       size = 16'd0;
          1:       size = 16'hFFFF;
          2:       size = 16'($urandom);
          default: size = 16'($urandom_range(1025, 65535));
        endcase
      end else begin
        k    = $urandom_range(0, 10);
        size = (k == 0) ? 16'd1 : 16'($urandom_range((1 << (k - 1)) + 1, 1 << k));
      end
      request_block(size);
    end else if (r < 85) begin
      pick  = $urandom_range(0, pool.live_blocks.size() - 1);
      faddr = pool.live_blocks[pick];
      // an occasional double free leaves the block in the live list
      if ($urandom_range(0, 19) != 0) pool.live_blocks.delete(pick);
      return_block(faddr);
    end else if (r < 93 && pool.live_blocks.size() > 0) begin
      pick = $urandom_range(0, pool.live_blocks.size() - 1);
      return_block(24'(pool.live_blocks[pick] + $urandom_range(1, 7)));
    end else begin
      return_block(24'($urandom));
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pool.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_counts(int phase);
    bit [CFG_W-1:0] value;
    drain();
    for (int i = 0; i < NUM_REGS; i++) begin
      case (phase)
        1:       value = '0;
        2:       value = '1;
        3: begin
          case ($urandom_range(0, 3))
            0:       value = 14'd0;
            1:       value = 14'd1;
            2:       value = 14'd8192;
            default: value = 14'($urandom);
          endcase
        end
        default: value = ($urandom_range(0, 9) == 0) ? 14'd0 : 14'($urandom_range(1, 5));
      endcase
      cfg_we_i    <= 1'b1;
      cfg_index_i <= REG_IDX_W'(i);
      cfg_data_i  <= value;
      @(posedge clk_i);
      pool.write_reg(i, value);
    end
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      pool.check_result(granted_o, block_address_o, served_class_o, status_o);
  end

  // receiver; one long hold-off backs the block up into its input
  initial begin
    int  hold, run;
    bit  pressed;
    pressed = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!pressed && pool.checked >= 400) begin
        hold    = 400;
        pressed = 1;
      end else begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (run) @(posedge clk_i);
    end
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int n_items;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    request_block(16'd0);
    request_block(16'hFFFF);
    request_block(16'd1025);
    request_block(16'd1);
    return_block(pool.last_alloc);
    request_block(16'd2);
    request_block(16'd8);
    request_block(16'd9);
    request_block(16'd16);
    request_block(16'd17);
    request_block(16'd33);
    request_block(16'd64);
    request_block(16'd65);
    request_block(16'd128);
    request_block(16'd129);
    request_block(16'd512);
    request_block(16'd1024);
    return_block(pool.last_alloc);
    return_block(pool.last_alloc);
    request_block(16'd1000);
    request_block(16'd1000);
    return_block(24'hFFFFFF);
    return_block(24'h000000);
    return_block(24'h000003);
    return_block(24'h0F0000);
    return_block(24'h0E0001);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) program_counts(phase);
      case (phase)
        0:       n_items = 80;
        1:       n_items = 40;
        2:       n_items = 100;
        default: n_items = 110;
      endcase
      repeat (n_items) send_random();
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (pool.errors == 0 && pool.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
